FILE: hdl/bffa_pkg.sv
// Shared types and constants for the bitmap first-fit allocator.
`timescale 1ns / 1ps
package bffa_pkg;

  localparam int unsigned MW  = 32;
  localparam int unsigned MBW = 5;
  localparam int unsigned FW  = 11;

  localparam logic [FW-1:0] ACTIVE_RST = 11'd1024;

  typedef logic [1:0] status_t;

  localparam status_t ST_OK           = 2'd0;
  localparam status_t ST_FULL         = 2'd1;
  localparam status_t ST_RANGE        = 2'd2;
  localparam status_t ST_ALREADY_FREE = 2'd3;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef struct packed {
    logic    capture_alloc;
    logic    capture_free;
    logic    adv;
    logic    commit_alloc;
    logic    commit_free;
    logic    res_load;
    logic    res_grant;
    status_t res_status;
    logic    push;
  } cmd_t;

  typedef struct packed {
    logic op;
    logic eff_zero;
    logic num_bad;
    logic hit;
    logic scan_last;
    logic tgt_set;
    logic out_free;
  } sts_t;

endpackage

FILE: hdl/bffa_if.sv
// Request, response and configuration channel interfaces.
`timescale 1ns / 1ps
interface bffa_req_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [10:0] entry_number;
  modport source (output valid, output operation, output entry_number, input ready);
  modport sink (input valid, input operation, input entry_number, output ready);
endinterface

interface bffa_rsp_if;
  logic        valid;
  logic        ready;
  logic [10:0] granted_entry;
  logic [1:0]  status;
  logic [10:0] free_count;
  modport source (output valid, output granted_entry, output status, output free_count,
                  input ready);
  modport sink (input valid, input granted_entry, input status, input free_count,
                output ready);
endinterface

interface bffa_cfg_if;
  logic        valid;
  logic        ready;
  logic [10:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/bffa_datapath.sv
// Datapath: map memory, row valid bits, counters, word search and result registers.
`timescale 1ns / 1ps
module bffa_datapath #(
  parameter int unsigned MAP_ENTRIES = 1024
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  bffa_pkg::cmd_t            cmd_i,
  output bffa_pkg::sts_t            sts_o,
  input  logic                      cfg_we_i,
  input  logic [bffa_pkg::FW-1:0]   cfg_data_i,
  input  logic                      operation_i,
  input  logic [bffa_pkg::FW-1:0]   entry_number_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [bffa_pkg::FW-1:0]   granted_o,
  output bffa_pkg::status_t         status_o,
  output logic [bffa_pkg::FW-1:0]   free_count_o
);

  localparam int unsigned MW    = bffa_pkg::MW;
  localparam int unsigned MBW   = bffa_pkg::MBW;
  localparam int unsigned FW    = bffa_pkg::FW;
  localparam int unsigned WORDS = (MAP_ENTRIES + MW - 1) / MW;
  localparam int unsigned WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned TIW   = WAW + MBW;
  localparam int unsigned CW    = $clog2(MAP_ENTRIES + 1);
  localparam int unsigned EW    = (CW > FW) ? CW : FW;

  logic [MW-1:0]    mem_q [WORDS];
  logic [WORDS-1:0] rvld_q;
  logic [MW-1:0]    rdata_q;
  logic             rd_vld_q;
  logic [FW-1:0]    active_q;
  logic [CW-1:0]    used_q;
  logic [WAW-1:0]   scan_w_q;
  logic [TIW-1:0]   tgt_q;
  logic [FW-1:0]    res_granted_q;
  bffa_pkg::status_t res_status_q;
  logic             out_valid_q;
  logic [FW-1:0]    out_granted_q;
  bffa_pkg::status_t out_status_q;
  logic [FW-1:0]    out_free_q;

  logic [EW-1:0]    active_ext;
  logic [EW-1:0]    eff;
  logic [EW-1:0]    eff_w;
  logic [EW-1:0]    used_ext;
  logic [EW-1:0]    free_cnt;
  logic [WAW-1:0]   last_w;
  logic [WAW-1:0]   raddr;
  logic [WAW-1:0]   waddr;
  logic [MW-1:0]    wdata;
  logic             we;
  logic [MW-1:0]    word_cur;
  logic [MW-1:0]    mask;
  logic [MW-1:0]    busy;
  logic [MBW-1:0]   fz;
  logic [TIW-1:0]   in_tgt;
  logic [FW-1:0]    grant_num;

  always_comb begin
    active_ext = EW'(active_q);
    eff        = (active_ext > EW'(MAP_ENTRIES)) ? EW'(MAP_ENTRIES) : active_ext;
    eff_w      = eff >> MBW;
    used_ext   = EW'(used_q);
    free_cnt   = (eff > used_ext) ? (eff - used_ext) : '0;
    last_w     = WAW'((eff - EW'(1)) >> MBW);
    word_cur   = rd_vld_q ? rdata_q : '0;
    in_tgt     = TIW'(entry_number_i - FW'(1));
  end

  always_comb begin
    if (EW'(scan_w_q) < eff_w) begin
      mask = '1;
    end else if (EW'(scan_w_q) == eff_w) begin
      mask = (MW'(1) << eff[MBW-1:0]) - MW'(1);
    end else begin
      mask = '0;
    end
    busy = word_cur | ~mask;
  end

  always_comb begin
    fz = '0;
    for (int i = MW - 1; i >= 0; i--) begin
      if (!busy[i]) begin
        fz = MBW'(i);
      end
    end
  end

  assign grant_num = FW'({scan_w_q, fz}) + FW'(1);

  always_comb begin
    sts_o.op        = operation_i;
    sts_o.eff_zero  = (eff == '0);
    sts_o.num_bad   = (entry_number_i == '0) || (EW'(entry_number_i) > eff);
    sts_o.hit       = ~&busy;
    sts_o.scan_last = (scan_w_q == last_w);
    sts_o.tgt_set   = word_cur[tgt_q[MBW-1:0]];
    sts_o.out_free  = !out_valid_q || out_ready_i;
  end

  always_comb begin
    if (cmd_i.capture_free) begin
      raddr = in_tgt[TIW-1:MBW];
    end else if (cmd_i.capture_alloc) begin
      raddr = '0;
    end else if (scan_w_q == last_w) begin
      raddr = scan_w_q;
    end else begin
      raddr = scan_w_q + WAW'(1);
    end
  end

  always_comb begin
    we = cmd_i.commit_alloc || cmd_i.commit_free;
    if (cmd_i.commit_alloc) begin
      waddr = scan_w_q;
      wdata = word_cur | (MW'(1) << fz);
    end else begin
      waddr = tgt_q[TIW-1:MBW];
      wdata = word_cur & ~(MW'(1) << tgt_q[MBW-1:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rvld_q   <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= rvld_q[raddr];
      if (we) begin
        rvld_q[waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= bffa_pkg::ACTIVE_RST;
      used_q      <= '0;
      scan_w_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        active_q <= cfg_data_i;
      end
      if (cmd_i.commit_alloc) begin
        used_q <= used_q + CW'(1);
      end else if (cmd_i.commit_free && used_q != '0) begin
        used_q <= used_q - CW'(1);
      end
      if (cmd_i.capture_alloc) begin
        scan_w_q <= '0;
      end else if (cmd_i.adv) begin
        scan_w_q <= scan_w_q + WAW'(1);
      end
      if (cmd_i.push) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture_free) begin
      tgt_q <= in_tgt;
    end
    if (cmd_i.res_load) begin
      res_granted_q <= cmd_i.res_grant ? grant_num : '0;
      res_status_q  <= cmd_i.res_status;
    end
    if (cmd_i.push) begin
      out_granted_q <= res_granted_q;
      out_status_q  <= res_status_q;
      out_free_q    <= FW'(free_cnt);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign granted_o    = out_granted_q;
  assign status_o     = out_status_q;
  assign free_count_o = out_free_q;

endmodule

FILE: hdl/bffa_ctrl.sv
// Controller state machine: request intake, map scan, free check, result hand-off.
`timescale 1ns / 1ps
module bffa_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  output logic           req_ready_o,
  input  bffa_pkg::sts_t sts_i,
  output bffa_pkg::cmd_t cmd_o
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_FREE   = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  logic [1:0] state_q;
  logic [1:0] state_d;
  logic       accept;

  assign req_ready_o = (state_q == S_IDLE);
  assign accept      = req_valid_i && req_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (sts_i.op == bffa_pkg::OP_ALLOC) begin
            if (sts_i.eff_zero) begin
              cmd_o.res_load   = 1'b1;
              cmd_o.res_status = bffa_pkg::ST_FULL;
              state_d          = S_FINISH;
            end else begin
              cmd_o.capture_alloc = 1'b1;
              state_d             = S_SCAN;
            end
          end else begin
            if (sts_i.num_bad) begin
              cmd_o.res_load   = 1'b1;
              cmd_o.res_status = bffa_pkg::ST_RANGE;
              state_d          = S_FINISH;
            end else begin
              cmd_o.capture_free = 1'b1;
              state_d            = S_FREE;
            end
          end
        end
      end
      S_SCAN: begin
        priority if (sts_i.hit) begin
          cmd_o.commit_alloc = 1'b1;
          cmd_o.res_load     = 1'b1;
          cmd_o.res_grant    = 1'b1;
          cmd_o.res_status   = bffa_pkg::ST_OK;
          state_d            = S_FINISH;
        end else if (sts_i.scan_last) begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = bffa_pkg::ST_FULL;
          state_d          = S_FINISH;
        end else begin
          cmd_o.adv = 1'b1;
        end
      end
      S_FREE: begin
        cmd_o.res_load = 1'b1;
        if (sts_i.tgt_set) begin
          cmd_o.commit_free = 1'b1;
          cmd_o.res_status  = bffa_pkg::ST_OK;
        end else begin
          cmd_o.res_status = bffa_pkg::ST_ALREADY_FREE;
        end
        state_d = S_FINISH;
      end
      S_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.push = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: hdl/bitmap_first_fit_allocator_core.sv
// Bitmap first-fit allocator: top level joining controller and datapath.
// Allocate: scans from map word 0, one 32-bit map word per cycle from the map memory,
//   until a free entry is found or the last active word has been searched.
// Rejected request (no active entries, number out of range): answered without a scan.
// One request in flight; the next is taken while a response waits.
// Reset clears the map at once through per-word valid bits; active_entries resets to 1024.
`timescale 1ns / 1ps
module bitmap_first_fit_allocator_core #(
  parameter int unsigned MAP_ENTRIES = 1024
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bffa_cfg_if.sink  cfg_i,
  bffa_req_if.sink  req_i,
  bffa_rsp_if.source rsp_o
);

  bffa_pkg::cmd_t cmd;
  bffa_pkg::sts_t sts;
  logic           req_ready;

  assign cfg_i.ready = 1'b1;
  assign req_i.ready = req_ready;

  bffa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  bffa_datapath #(
    .MAP_ENTRIES (MAP_ENTRIES)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .cfg_we_i       (cfg_i.valid),
    .cfg_data_i     (cfg_i.data),
    .operation_i    (req_i.operation),
    .entry_number_i (req_i.entry_number),
    .out_valid_o    (rsp_o.valid),
    .out_ready_i    (rsp_o.ready),
    .granted_o      (rsp_o.granted_entry),
    .status_o       (rsp_o.status),
    .free_count_o   (rsp_o.free_count)
  );

endmodule

FILE: hdl/bffa_checker.sv
// Port-level checker for the allocator, bound to the top level.
`timescale 1ns / 1ps
module bffa_checker (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    req_valid_i,
  input logic                    req_ready_i,
  input logic                    rsp_valid_i,
  input logic                    rsp_ready_i,
  input logic [10:0]             rsp_granted_i,
  input bffa_pkg::status_t       rsp_status_i,
  input logic [10:0]             rsp_free_i
);

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_granted_i)
      && $stable(rsp_status_i) && $stable(rsp_free_i))
    else $error("response word changed while stalled");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while another is in progress");

  a_no_grant_on_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_status_i != bffa_pkg::ST_OK |-> rsp_granted_i == '0)
    else $error("entry granted with failing status");

  a_full_no_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_status_i == bffa_pkg::ST_FULL |-> rsp_free_i == '0)
    else $error("map full reported with free entries left");

endmodule

bind bitmap_first_fit_allocator_core bffa_checker u_bffa_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .req_valid_i   (req_i.valid),
  .req_ready_i   (req_i.ready),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .rsp_granted_i (rsp_o.granted_entry),
  .rsp_status_i  (rsp_o.status),
  .rsp_free_i    (rsp_o.free_count)
);

FILE: dv/testbench.sv
// Self-checking testbench for the bitmap first-fit allocator core.
`timescale 1ns / 1ps
module testbench;

  localparam int unsigned MAP_ENTRIES = 1024;
  localparam int unsigned LIMIT       = 500000;
  localparam int unsigned HOLD_CYCLES = 300;

  typedef struct packed {
    logic                    op;
    logic [bffa_pkg::FW-1:0] num;
  } request_t;

  typedef struct packed {
    logic [bffa_pkg::FW-1:0] granted;
    bffa_pkg::status_t       status;
    logic [bffa_pkg::FW-1:0] free_count;
  } reply_t;

  logic clk_i;
  logic rst_ni;

  bffa_cfg_if cfg_if();
  bffa_req_if req_if();
  bffa_rsp_if rsp_if();

  bitmap_first_fit_allocator_core #(
    .MAP_ENTRIES(MAP_ENTRIES)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_if),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  request_t                request_backlog[$];
  reply_t                  awaited_replies[$];
  logic                    entry_used[MAP_ENTRIES];
  int unsigned             in_use;
  logic [bffa_pkg::FW-1:0] active_cfg;
  logic                    quiet_mode;
  int unsigned             hold_asks;
  int unsigned             hold_seen;
  int unsigned             hold_left;
  int unsigned             errors;
  int unsigned             cycles;

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  function automatic int unsigned span_now();
    return (active_cfg > MAP_ENTRIES) ? MAP_ENTRIES : int'(active_cfg);
  endfunction

  function automatic reply_t grant_or_release(request_t rq);
    reply_t      r;
    int unsigned span;
    logic        hit;
    span = span_now();
    hit = 1'b0;
    r.granted = '0;
    r.status = bffa_pkg::ST_OK;
    if (rq.op == bffa_pkg::OP_ALLOC) begin
      r.status = bffa_pkg::ST_FULL;
      for (int unsigned i = 0; i < span && !hit; i++) begin
        if (!entry_used[i]) begin
          entry_used[i] = 1'b1;
          in_use++;
          r.granted = bffa_pkg::FW'(i + 1);
          r.status = bffa_pkg::ST_OK;
          hit = 1'b1;
        end
      end
    end else if (rq.num == 0 || rq.num > span) begin
      r.status = bffa_pkg::ST_RANGE;
    end else if (!entry_used[rq.num - 1]) begin
      r.status = bffa_pkg::ST_ALREADY_FREE;
    end else begin
      entry_used[rq.num - 1] = 1'b0;
      if (in_use > 0) in_use--;
    end
    r.free_count = (span > in_use) ? bffa_pkg::FW'(span - in_use) : '0;
    return r;
  endfunction

  // driver: hold the word until taken, then load the next one or idle
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        awaited_replies.push_back(grant_or_release('{op: req_if.operation,
                                                     num: req_if.entry_number}));
      end
      if (!req_if.valid || req_if.ready) begin
        if (request_backlog.size() != 0 && (quiet_mode || $urandom_range(99) >= 6)) begin
          req_if.valid        <= 1'b1;
          req_if.operation    <= request_backlog[0].op;
          req_if.entry_number <= request_backlog[0].num;
          void'(request_backlog.pop_front());
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      hold_left <= 0;
    end else if (hold_asks != hold_seen) begin
      hold_seen <= hold_asks;
      hold_left <= HOLD_CYCLES;
      rsp_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= quiet_mode || $urandom_range(99) >= 6;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    reply_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (awaited_replies.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected reply: granted %0d status %0d free %0d",
                   rsp_if.granted_entry, rsp_if.status, rsp_if.free_count);
      end else begin
        want = awaited_replies.pop_front();
        if (rsp_if.granted_entry !== want.granted || rsp_if.status !== want.status ||
            rsp_if.free_count !== want.free_count) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected granted %0d status %0d free %0d, got %0d %0d %0d",
                     want.granted, want.status, want.free_count,
                     rsp_if.granted_entry, rsp_if.status, rsp_if.free_count);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  task automatic queue_req(input logic op, input logic [bffa_pkg::FW-1:0] num);
    request_backlog.push_back('{op: op, num: num});
  endtask

  task automatic wait_idle();
    do @(posedge clk_i);
    while (request_backlog.size() != 0 || req_if.valid || awaited_replies.size() != 0);
  endtask

  task automatic write_active(input logic [bffa_pkg::FW-1:0] value);
    @(posedge clk_i);
    cfg_if.data  <= value;
    cfg_if.valid <= 1'b1;
    do @(posedge clk_i);
    while (!cfg_if.ready);
    active_cfg = value;
    cfg_if.valid <= 1'b0;
  endtask

  task automatic queue_random(input int unsigned n, input int unsigned alloc_pct);
    int unsigned span;
    span = span_now();
    for (int unsigned k = 0; k < n; k++) begin
      if ($urandom_range(99) < alloc_pct)
        queue_req(bffa_pkg::OP_ALLOC, bffa_pkg::FW'($urandom_range(2047)));
      else if ($urandom_range(99) < 10 || span == 0)
        queue_req(bffa_pkg::OP_FREE, ($urandom_range(3) == 0) ? '0 :
                  bffa_pkg::FW'($urandom_range(2047, span + 1)));
      else
        queue_req(bffa_pkg::OP_FREE, bffa_pkg::FW'($urandom_range(span, 1)));
    end
  endtask

  task automatic run_phase(input logic [bffa_pkg::FW-1:0] active, input int unsigned n,
                           input int unsigned alloc_pct, input logic quiet, input logic stall);
    write_active(active);
    quiet_mode = quiet;
    queue_random(n / 2, alloc_pct);
    if (stall) hold_asks++;
    wait_idle();
    queue_random(n - n / 2, alloc_pct);
    wait_idle();
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    req_if.valid = 1'b0;
    req_if.operation = bffa_pkg::OP_ALLOC;
    req_if.entry_number = '0;
    rsp_if.ready = 1'b0;
    for (int unsigned i = 0; i < MAP_ENTRIES; i++) entry_used[i] = 1'b0;
    in_use = 0;
    active_cfg = bffa_pkg::ACTIVE_RST;
    quiet_mode = 1'b0;
    hold_asks = 0;
    hold_seen = 0;
    errors = 0;
    cycles = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    queue_req(bffa_pkg::OP_ALLOC, '0);
    queue_req(bffa_pkg::OP_ALLOC, 11'd2047);
    queue_req(bffa_pkg::OP_ALLOC, '0);
    queue_req(bffa_pkg::OP_FREE, 11'd2);
    queue_req(bffa_pkg::OP_FREE, 11'd2);
    queue_req(bffa_pkg::OP_ALLOC, '0);
    queue_req(bffa_pkg::OP_FREE, 11'd0);
    queue_req(bffa_pkg::OP_FREE, 11'd1025);
    queue_req(bffa_pkg::OP_FREE, 11'd2047);
    queue_req(bffa_pkg::OP_FREE, 11'd1024);
    queue_req(bffa_pkg::OP_FREE, 11'd3);
    wait_idle();
    write_active(11'd0);
    queue_req(bffa_pkg::OP_ALLOC, '0);
    queue_req(bffa_pkg::OP_FREE, 11'd1);
    wait_idle();
    write_active(11'd2);
    queue_req(bffa_pkg::OP_ALLOC, '0);
    wait_idle();
    write_active(11'd1);
    queue_req(bffa_pkg::OP_ALLOC, '0);
    queue_req(bffa_pkg::OP_FREE, 11'd2);
    queue_req(bffa_pkg::OP_FREE, 11'd1);
    queue_req(bffa_pkg::OP_ALLOC, '0);
    wait_idle();
    write_active(11'd2047);
    queue_req(bffa_pkg::OP_ALLOC, '0);
    queue_req(bffa_pkg::OP_FREE, 11'd1024);
    wait_idle();

    run_phase(11'd5, 150, 55, 1'b0, 1'b0);
    run_phase(11'd33, 200, 60, 1'b0, 1'b1);
    run_phase(11'd700, 250, 50, 1'b1, 1'b0);
    run_phase(11'd1024, 550, 85, 1'b0, 1'b0);
    run_phase(11'd1, 60, 50, 1'b0, 1'b0);

    repeat (40) @(posedge clk_i);
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
